[hw/rtl/rcc_pkg.sv]
// Shared constants and codes for the rounded corner coverage pipeline.
package rcc_pkg;

  localparam int RCC_FRAC_BITS  = 8;
  localparam int RCC_MAX_RADIUS = 255;

  // Radius ceiling seen by the 8-bit radius register.
  localparam logic [7:0] RCC_RADIUS_CAP =
    8'((RCC_MAX_RADIUS > 255) ? 255 : RCC_MAX_RADIUS);

  localparam int RCC_CFG_IDX_W = 3;

  typedef enum logic [RCC_CFG_IDX_W-1:0] {
    RCC_REG_RADIUS = 3'd0,
    RCC_REG_SELECT = 3'd1,
    RCC_REG_RED    = 3'd2,
    RCC_REG_GREEN  = 3'd3,
    RCC_REG_BLUE   = 3'd4
  } rcc_reg_t;

  typedef enum logic [1:0] {
    RCC_CORNER_TL = 2'd0,
    RCC_CORNER_TR = 2'd1,
    RCC_CORNER_BL = 2'd2,
    RCC_CORNER_BR = 2'd3
  } rcc_corner_t;

endpackage

[hw/rtl/rcc_dist.sv]
// Squared distance to the circle centre, two register stages.
module rcc_dist (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [7:0]  pixel_column,
  input  logic [7:0]  pixel_row,
  input  logic [7:0]  radius,
  input  logic [1:0]  corner,
  output logic        vld_o,
  output logic [18:0] d2_o
);

  logic [8:0]         cx2;
  logic [8:0]         cy2;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic [8:0]         adx_nxt;
  logic [8:0]         ady_nxt;
  logic [8:0]         adx_r;
  logic [8:0]         ady_r;
  logic               vld1_r;
  logic [18:0]        d2_nxt;
  logic [18:0]        d2_r;
  logic               vld2_r;

  // centre in half-pixel units
  always_comb begin
    unique case (rcc_pkg::rcc_corner_t'(corner))
      rcc_pkg::RCC_CORNER_TL: begin
        cx2 = {radius, 1'b0};
        cy2 = {radius, 1'b0};
      end
      rcc_pkg::RCC_CORNER_TR: begin
        cx2 = 9'd0;
        cy2 = {radius, 1'b0};
      end
      rcc_pkg::RCC_CORNER_BL: begin
        cx2 = {radius, 1'b0};
        cy2 = 9'd0;
      end
      rcc_pkg::RCC_CORNER_BR: begin
        cx2 = 9'd0;
        cy2 = 9'd0;
      end
      default: begin
        cx2 = 9'd0;
        cy2 = 9'd0;
      end
    endcase
  end

  always_comb begin
    dx      = $signed({2'b00, pixel_column, 1'b1}) - $signed({2'b00, cx2});
    dy      = $signed({2'b00, pixel_row, 1'b1}) - $signed({2'b00, cy2});
    adx_nxt = dx[10] ? 9'(-dx) : dx[8:0];
    ady_nxt = dy[10] ? 9'(-dy) : dy[8:0];
    d2_nxt  = {1'b0, 18'(adx_r * adx_r)} + {1'b0, 18'(ady_r * ady_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r <= adx_nxt;
      ady_r <= ady_nxt;
      d2_r  <= d2_nxt;
    end
  end

  assign vld_o = vld2_r;
  assign d2_o  = d2_r;

endmodule

[hw/rtl/rcc_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module rcc_sqrt #(
  parameter int FRAC_BITS = rcc_pkg::RCC_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [18:0]          d2_i,
  output logic                 vld_o,
  output logic [FRAC_BITS+8:0] dist_o
);

  localparam int ROOT_W = FRAC_BITS + 9;
  localparam int REM_W  = ROOT_W + 2;
  localparam int V_W    = 2 * ROOT_W;

  logic [V_W-1:0]    v0;
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [V_W-1:0]    v_r    [ROOT_W];
  logic              vld_r  [ROOT_W];

  // d2 scaled by 2^(2F-2), radicand consumed two bits per stage from the top
  assign v0 = {1'b0, d2_i, {(2*FRAC_BITS-2){1'b0}}};

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [V_W-1:0]    v_in;
    logic              vld_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  cand;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [V_W-1:0]    v_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = v0;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign v_in    = v_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    always_comb begin
      trial    = {rem_in, v_in[V_W-1 -: 2]};
      cand     = {2'b00, root_in, 2'b01};
      ge       = (trial >= cand);
      rem_nxt  = ge ? REM_W'(trial - cand) : REM_W'(trial);
      root_nxt = {root_in[ROOT_W-2:0], ge};
      v_nxt    = {v_in[V_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        v_r[i]    <= v_nxt;
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign dist_o = root_r[ROOT_W-1];

endmodule

[hw/rtl/rcc_shade.sv]
// Coverage clamp and premultiplied colour, two register stages.
module rcc_shade #(
  parameter int FRAC_BITS = rcc_pkg::RCC_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [FRAC_BITS+8:0] dist_i,
  input  logic [7:0]           radius,
  input  logic [7:0]           fill_red,
  input  logic [7:0]           fill_green,
  input  logic [7:0]           fill_blue,
  output logic                 vld_o,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_green,
  output logic [7:0]           out_red,
  output logic [7:0]           out_alpha
);

  localparam int S_W   = FRAC_BITS + 11;
  localparam int COV_W = FRAC_BITS + 1;
  localparam int P_W   = FRAC_BITS + 9;
  localparam logic [S_W-1:0] HALF_S = S_W'(1) << (FRAC_BITS - 1);
  localparam logic [S_W-1:0] ONE_S  = S_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0] HALF_P = P_W'(1) << (FRAC_BITS - 1);

  logic signed [S_W-1:0] cov_s;
  logic [COV_W-1:0]      cov_nxt;
  logic [COV_W-1:0]      cov_r;
  logic                  vld1_r;
  logic [P_W-1:0]        blue_p;
  logic [P_W-1:0]        green_p;
  logic [P_W-1:0]        red_p;
  logic [P_W-1:0]        alpha_p;
  logic [7:0]            blue_r;
  logic [7:0]            green_r;
  logic [7:0]            red_r;
  logic [7:0]            alpha_r;
  logic                  vld2_r;

  always_comb begin
    cov_s = $signed({2'b00, dist_i}) - $signed({3'b000, radius, {FRAC_BITS{1'b0}}})
            + $signed(HALF_S);
    priority if (cov_s[S_W-1]) begin
      cov_nxt = '0;
    end else if (cov_s > $signed(ONE_S)) begin
      cov_nxt = ONE_S[COV_W-1:0];
    end else begin
      cov_nxt = cov_s[COV_W-1:0];
    end
  end

  // round half up, then keep the 8-bit field
  always_comb begin
    blue_p  = P_W'(fill_blue)  * P_W'(cov_r) + HALF_P;
    green_p = P_W'(fill_green) * P_W'(cov_r) + HALF_P;
    red_p   = P_W'(fill_red)   * P_W'(cov_r) + HALF_P;
    alpha_p = P_W'(8'd255)     * P_W'(cov_r) + HALF_P;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov_r   <= cov_nxt;
      blue_r  <= blue_p[FRAC_BITS+7:FRAC_BITS];
      green_r <= green_p[FRAC_BITS+7:FRAC_BITS];
      red_r   <= red_p[FRAC_BITS+7:FRAC_BITS];
      alpha_r <= alpha_p[FRAC_BITS+7:FRAC_BITS];
    end
  end

  assign vld_o     = vld2_r;
  assign out_blue  = blue_r;
  assign out_green = green_r;
  assign out_red   = red_r;
  assign out_alpha = alpha_r;

endmodule

[hw/rtl/rounded_corner_coverage_pixel_top.sv]
// Top level of the antialiased rounded corner coverage pipeline.
//
//   channel | dir | handshake                 | word
//   --------+-----+---------------------------+---------------------------------
//   in_     | in  | in_tvalid / in_tready     | 16b: column, row
//   out_    | out | out_tvalid / out_tready   | 32b: blue, green, red, alpha
//   cfg_    | in  | cfg_valid / cfg_ready     | 3b index, 8b data (always ready)
//
// One word in and one word out per clock while the output is taken.
// Register stages: two for the squared distance, FRAC_BITS + 9 root stages in the
// square root, two for coverage and colour.
// rst_n is synchronous: clears the stage valid bits, loads radius 8, top-left, black.
// A word held at the output freezes every stage, bubbles included; nothing is lost.
// Registers are read live by the stages, so write them only when idle.
module rounded_corner_coverage_pixel_top #(
  parameter int FRAC_BITS = rcc_pkg::RCC_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // pixel_column, pixel_row
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // out_blue, out_green, out_red, out_alpha
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcc_pkg::RCC_CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data
);

  logic [7:0]           radius_r;
  logic [1:0]           select_r;
  logic [7:0]           red_r;
  logic [7:0]           green_r;
  logic [7:0]           blue_r;
  logic [7:0]           radius_eff;
  logic                 en;
  logic                 d2_vld;
  logic [18:0]          d2;
  logic                 dist_vld;
  logic [FRAC_BITS+8:0] root_dist;
  logic [7:0]           o_blue;
  logic [7:0]           o_green;
  logic [7:0]           o_red;
  logic [7:0]           o_alpha;

  // register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 8'd8;
      select_r <= rcc_pkg::RCC_CORNER_TL;
      red_r    <= 8'd0;
      green_r  <= 8'd0;
      blue_r   <= 8'd0;
    end else if (cfg_valid) begin
      unique case (rcc_pkg::rcc_reg_t'(cfg_index))
        rcc_pkg::RCC_REG_RADIUS: radius_r <= cfg_data;
        rcc_pkg::RCC_REG_SELECT: select_r <= cfg_data[1:0];
        rcc_pkg::RCC_REG_RED:    red_r    <= cfg_data;
        rcc_pkg::RCC_REG_GREEN:  green_r  <= cfg_data;
        rcc_pkg::RCC_REG_BLUE:   blue_r   <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // saturate radius to the configured ceiling
  assign radius_eff = (radius_r > rcc_pkg::RCC_RADIUS_CAP) ? rcc_pkg::RCC_RADIUS_CAP
                                                           : radius_r;

  // whole pipe advances unless the output word is stuck
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rcc_dist u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_i        (in_tvalid),
    .pixel_column (in_tdata[7:0]),
    .pixel_row    (in_tdata[15:8]),
    .radius       (radius_eff),
    .corner       (select_r),
    .vld_o        (d2_vld),
    .d2_o         (d2)
  );

  rcc_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d2_vld),
    .d2_i   (d2),
    .vld_o  (dist_vld),
    .dist_o (root_dist)
  );

  rcc_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_i      (dist_vld),
    .dist_i     (root_dist),
    .radius     (radius_eff),
    .fill_red   (red_r),
    .fill_green (green_r),
    .fill_blue  (blue_r),
    .vld_o      (out_tvalid),
    .out_blue   (o_blue),
    .out_green  (o_green),
    .out_red    (o_red),
    .out_alpha  (o_alpha)
  );

  assign out_tdata = {o_alpha, o_red, o_green, o_blue};

endmodule

[tb/tb_rounded_corner_coverage_pixel_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the rounded corner coverage pipeline, with its own pixel shader model.
module tb_rounded_corner_coverage_pixel_top;
  import rcc_pkg::*;

  localparam int FRAC      = RCC_FRAC_BITS;
  localparam int HALF      = 1 << (FRAC - 1);
  localparam int LATENCY   = FRAC + 13;     // pipeline depth given by the top level
  localparam int HOLD_OFF  = 300;           // long receiver hold-off, in cycles
  localparam int QUIET_MAX = 2000;          // cycles with no word moved before giving up

  // Result word as it sits on out_tdata: blue in the low byte, alpha at the top.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shell_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  rcc_reg_t    cfg_index  = RCC_REG_RADIUS;
  logic [7:0]  cfg_data   = '0;

  // Shadow copy of the block's registers, updated as each write is taken.
  logic [7:0]  radius_reg = 8'd8;
  rcc_corner_t corner_reg = RCC_CORNER_TL;
  logic [7:0]  red_reg    = '0;
  logic [7:0]  green_reg  = '0;
  logic [7:0]  blue_reg   = '0;

  shell_word_t expected_pixels[$];
  int          error_count = 0;
  int          quiet_cycles = 0;

  // Sender and receiver idling controls.
  bit          tx_gaps = 1'b1;
  logic        rx_gaps = 1'b1;
  int          hold_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  rounded_corner_coverage_pixel_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // pixel_column, pixel_row
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // out_blue, out_green, out_red, out_alpha
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shader model
  // ---------------------------------------------------------------------------

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Shell colour of one pixel, premultiplied by the part of it outside the curve.
  function automatic shell_word_t shade_pixel(input logic [7:0] col, input logic [7:0] row);
    int          r;
    int          cx2;
    int          cy2;
    int          dx;
    int          dy;
    logic [63:0] d2;
    logic [63:0] dist_fx;
    longint      cov_s;
    int          cov;
    shell_word_t p;
    r   = (radius_reg > RCC_RADIUS_CAP) ? int'(RCC_RADIUS_CAP) : int'(radius_reg);
    // Centre sits on the inner corner of the square: x = r on the left corners,
    // y = r on the top ones.
    cx2 = (corner_reg == RCC_CORNER_TL || corner_reg == RCC_CORNER_BL) ? 2 * r : 0;
    cy2 = (corner_reg == RCC_CORNER_TL || corner_reg == RCC_CORNER_TR) ? 2 * r : 0;
    dx  = 2 * int'(col) + 1 - cx2;
    dy  = 2 * int'(row) + 1 - cy2;
    d2  = 64'(dx * dx) + 64'(dy * dy);
    dist_fx = floor_root(d2 << (2 * FRAC - 2));
    cov_s   = longint'(dist_fx) - (longint'(r) << FRAC) + HALF;
    if (cov_s < 0)
      cov = 0;
    else if (cov_s > (1 << FRAC))
      cov = 1 << FRAC;
    else
      cov = int'(cov_s);
    p.blue  = 8'((int'(blue_reg) * cov + HALF) >> FRAC);
    p.green = 8'((int'(green_reg) * cov + HALF) >> FRAC);
    p.red   = 8'((int'(red_reg) * cov + HALF) >> FRAC);
    p.alpha = 8'((cov * 255 + HALF) >> FRAC);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_receiver
    if (hold_seen != hold_asked) begin
      hold_seen  <= hold_asked;
      hold_left  <= HOLD_OFF;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      // start of a stall burst, this one included; stall_left counts the rest
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_checker
    shell_word_t got;
    shell_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pixels.size() == 0) begin
        $error("result word %h with nothing expected", out_tdata);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
          error_count++;
        end
        if (got.green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, got.green);
          error_count++;
        end
        if (got.red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, got.red);
          error_count++;
        end
        if (got.alpha !== want.alpha) begin
          $error("out_alpha: expected %0d, got %0d", want.alpha, got.alpha);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on any channel.
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("rounded_corner_coverage_pixel_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One pixel word; optional gap before it. Leaves in_tvalid high.
  task automatic send_pixel(input logic [7:0] col, input logic [7:0] row);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    do @(posedge clk); while (!in_tready);
    expected_pixels.push_back(shade_pixel(col, row));
  endtask

  // Stop sending, wait for every result, then let the pipe run empty.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // One register write; leaves cfg_valid high for a following write.
  task automatic write_register(input rcc_reg_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RCC_REG_RADIUS: radius_reg = value;
      RCC_REG_SELECT: corner_reg = rcc_corner_t'(value[1:0]);
      RCC_REG_RED:    red_reg    = value;
      RCC_REG_GREEN:  green_reg  = value;
      RCC_REG_BLUE:   blue_reg   = value;
      default: ;  // unused index, nothing changes
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] radius, input rcc_corner_t corner,
                                input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue);
    drain_pipeline();
    write_register(RCC_REG_RADIUS, radius);
    // junk in the upper bits of the select word must be masked off
    write_register(RCC_REG_SELECT, {6'($urandom_range(0, 63)), corner});
    write_register(RCC_REG_RED, red);
    write_register(RCC_REG_GREEN, green);
    write_register(RCC_REG_BLUE, blue);
    cfg_valid <= 1'b0;
  endtask

  // Small radii more often: there the antialiased band covers much of the square.
  function automatic logic [7:0] pick_radius();
    case ($urandom_range(0, 9))
      0:       return 8'd255;
      1:       return 8'd1;
      2:       return 8'd0;
      3, 4, 5: return 8'($urandom_range(2, 16));
      default: return 8'($urandom_range(17, 254));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly inside the square, sometimes anywhere in the field's range.
  function automatic logic [7:0] pick_coord();
    if (radius_reg == 0 || $urandom_range(0, 7) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, int'(radius_reg) - 1));
  endfunction

  task automatic random_settings();
    apply_settings(pick_radius(), rcc_corner_t'($urandom_range(0, 3)),
                   pick_level(), pick_level(), pick_level());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: radius 8, top-left, black shell.
  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd7, 8'd7);
    send_pixel(8'd3, 8'd5);
    send_pixel(8'd255, 8'd255);
  endtask

  // Largest radius at every corner, far and near pixels, all-ones and alternating colour bits.
  task automatic test_full_radius_corners();
    for (int k = 0; k < 4; k++) begin
      apply_settings(8'd255, rcc_corner_t'(k), 8'hFF, 8'hAA, 8'h55);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd254, 8'd254);
      send_pixel(8'hAA, 8'h55);
    end
  endtask

  // Zero radius: nothing skipped, centre on the corner itself.
  task automatic test_zero_radius();
    apply_settings(8'd0, RCC_CORNER_TL, 8'h80, 8'h01, 8'hFF);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
  endtask

  // Unit radius, with a pixel outside the square.
  task automatic test_unit_radius();
    apply_settings(8'd1, RCC_CORNER_BR, 8'h55, 8'hFF, 8'hAA);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd1, 8'd1);
  endtask

  // Writes to indexes past the register list must leave everything alone.
  task automatic test_unused_index();
    drain_pipeline();
    for (int k = 1; k <= 3; k++)
      write_register(rcc_reg_t'(RCC_REG_BLUE + k), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    send_pixel(8'd0, 8'd1);
    send_pixel(8'd1, 8'd0);
  endtask

  // Random settings per phase; some phases run without idling on one side or on both.
  task automatic test_random_pixels();
    for (int phase = 0; phase < 14; phase++) begin
      random_settings();
      tx_gaps = (phase % 3 != 2);
      rx_gaps <= (phase % 4 != 3);
      repeat (60) send_pixel(pick_coord(), pick_coord());
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming: the pipe
  // fills and in_tready has to drop.
  task automatic test_backpressure();
    random_settings();
    tx_gaps = 1'b0;
    hold_asked <= hold_asked + 1;
    repeat (80) send_pixel(pick_coord(), pick_coord());
  endtask

  // Last stretch at full rate, no idling on either side.
  task automatic test_closing_burst();
    random_settings();
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    repeat (60) send_pixel(pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_radius_corners();
    test_zero_radius();
    test_unit_radius();
    test_unused_index();
    test_random_pixels();
    test_backpressure();
    test_closing_burst();

    drain_pipeline();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("rounded_corner_coverage_pixel_top: match");
    end else begin
      $display("rounded_corner_coverage_pixel_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_dist.sv
hw/rtl/rcc_sqrt.sv
hw/rtl/rcc_shade.sv
hw/rtl/rounded_corner_coverage_pixel_top.sv
tb/tb_rounded_corner_coverage_pixel_top.sv
